>>> rtl/mds_pkg.sv
// Shared types and constants for the diverse-selection block.
`default_nettype none
package mds_pkg;

  localparam int ELEM_W = 16;   // Q1.14 element / relevance
  localparam int SIM_W  = 40;   // saturated similarity
  localparam int LAM_W  = 17;   // Q0.16 weight, 65536 = 1.0
  localparam int PAD_W  = 4;    // APB address width
  localparam int IDX_W  = 10;   // pick_index field
  localparam int RANK_W = 6;    // pick_rank field

  localparam logic [LAM_W-1:0] LAM_ONE = 17'd65536;

  localparam logic [8:0]       VDIM_RST   = 9'd256;
  localparam logic [6:0]       PICKS_RST  = 7'd10;
  localparam logic [LAM_W-1:0] LAMBDA_RST = 17'd32768;

  typedef enum logic [1:0] {
    REG_VECTOR_DIM    = 2'd0,
    REG_PICKS_WANTED  = 2'd1,
    REG_LAMBDA_WEIGHT = 2'd2
  } reg_idx_t;

endpackage
`default_nettype wire

>>> rtl/mds_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/mds_cell.sv
// One cell of the rotating chain that holds the last picked vector.
`default_nettype none
module mds_cell
  import mds_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [ELEM_W-1:0] d,
  output logic signed      [ELEM_W-1:0] q
);
  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/mmr_diverse_selection.sv
// Top level: greedy maximal-marginal-relevance selection over a loaded set.
// Usage:
//  - Slave stream takes one vector element per word; tdata carries elem_value
//    (bits 15:0) and relevance (bits 31:16, used on a candidate's first
//    element); tlast closes the set and starts selection.
//  - Loading takes one word per cycle. After tlast the slave side is held off
//    until the final pick has been loaded into the output register.
//  - Selection: a zero pad of the last partial vector, a clear of ncand state
//    entries, then per pick a scan of the ncand candidates and, unless it is
//    the last pick, a chain load of the picked vector plus one dot product per
//    candidate. The dot product runs one element per cycle through the single
//    vector RAM read port against a rotating chain of MAX_DIM cells holding
//    the picked vector.
//  - Master stream: one word per pick; tdata = pick_index (9:0),
//    pick_rank (15:10); tlast marks the final pick. A stalled receiver holds
//    selection at the next pick; nothing is dropped.
//  - APB registers: vector_dim at 0x0, picks_wanted at 0x4, lambda_weight
//    at 0x8. Write only while idle.
//  - Synchronous reset clears control state and restores register defaults;
//    RAM contents are not cleared.
`default_nettype none
module mmr_diverse_selection
  import mds_pkg::*;
#(
  parameter int MAX_CANDS = 1024,
  parameter int MAX_DIM   = 256,
  parameter int MAX_PICKS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // slave stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [31:0]      s_tdata,   // elem_value[15:0], relevance[31:16]
  input  wire logic             s_tlast,
  // master stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [15:0]           m_tdata,   // pick_index[9:0], pick_rank[15:10]
  output logic                  m_tlast,
  // APB
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [PAD_W-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);
  localparam int CIW = (MAX_CANDS > 1) ? $clog2(MAX_CANDS) : 1;
  localparam int CCW = $clog2(MAX_CANDS + 1);
  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int VD  = MAX_CANDS * MAX_DIM;
  localparam int VAW = (VD > 1) ? $clog2(VD) : 1;
  localparam int VBW = $clog2(VD + 1);
  localparam int NW  = (CCW > 7) ? CCW : 7;
  localparam int CW9 = (DW > 9) ? DW : 9;
  localparam int SW  = 60;
  localparam int AW  = (33 + $clog2(MAX_DIM) > 41) ? 33 + $clog2(MAX_DIM) : 41;
  localparam int STW = SIM_W + 1;   // {picked flag, max similarity}

  localparam logic signed [AW-1:0] SMAX = {{(AW-SIM_W+1){1'b0}}, {(SIM_W-1){1'b1}}};
  localparam logic signed [AW-1:0] SMIN = {{(AW-SIM_W+1){1'b1}}, {(SIM_W-1){1'b0}}};

  typedef enum logic [8:0] {
    S_LOAD     = 9'b000000001,
    S_PAD      = 9'b000000010,
    S_CLEAR    = 9'b000000100,
    S_SCAN     = 9'b000001000,
    S_SCAN_END = 9'b000010000,
    S_EMIT     = 9'b000100000,
    S_CHAIN_LD = 9'b001000000,
    S_DOT_RUN  = 9'b010000000,
    S_DOT_END  = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic [8:0]       vector_dim;
  logic [6:0]       picks_wanted;
  logic [LAM_W-1:0] lambda_weight;

  logic apb_wr;
  assign pready = 1'b1;
  assign apb_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_dim    <= VDIM_RST;
      picks_wanted  <= PICKS_RST;
      lambda_weight <= LAMBDA_RST;
    end else if (apb_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_VECTOR_DIM:    vector_dim    <= pwdata[8:0];
        REG_PICKS_WANTED:  picks_wanted  <= pwdata[6:0];
        REG_LAMBDA_WEIGHT: lambda_weight <= pwdata[LAM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_VECTOR_DIM:    prdata = {23'd0, vector_dim};
      REG_PICKS_WANTED:  prdata = {25'd0, picks_wanted};
      REG_LAMBDA_WEIGHT: prdata = {15'd0, lambda_weight};
      default:           prdata = 32'd0;
    endcase
  end

  // load counters
  logic [DW-1:0]  set_dim, ld_e, dim_use, dim_clamp, e_inc;
  logic [CCW-1:0] ld_c, ncand, idx;
  logic [VBW-1:0] ld_base, dbase, best_base;
  logic [6:0]     npicks, rank;
  logic [LAM_W-1:0] lam_c, inv_c;
  logic [DW-1:0]  k;
  logic [1:0]     drain;

  logic in_acc, first_elem, room;
  assign s_tready   = (state == S_LOAD);
  assign in_acc     = s_tvalid & s_tready;
  assign first_elem = (ld_c == '0) && (ld_e == '0);
  assign room       = ld_c < CCW'(MAX_CANDS);
  assign e_inc      = ld_e + 1'b1;

  always_comb begin
    if (vector_dim == 9'd0) begin
      dim_clamp = DW'(1);
    end else if (CW9'(vector_dim) > CW9'(MAX_DIM)) begin
      dim_clamp = DW'(MAX_DIM);
    end else begin
      dim_clamp = DW'(vector_dim);
    end
    dim_use = first_elem ? dim_clamp : set_dim;
  end

  // selection-time clamps
  logic [6:0]       pw_c;
  logic [NW-1:0]    np_w;
  logic [LAM_W-1:0] lam_sat;
  always_comb begin
    pw_c    = (picks_wanted > 7'(MAX_PICKS)) ? 7'(MAX_PICKS) : picks_wanted;
    np_w    = (NW'(pw_c) > NW'(ncand)) ? NW'(ncand) : NW'(pw_c);
    lam_sat = (lambda_weight > LAM_ONE) ? LAM_ONE : lambda_weight;
  end

  // RAMs
  logic              vec_we;
  logic [VAW-1:0]    vec_waddr, vec_raddr;
  logic [ELEM_W-1:0] vec_wdata, vec_q;
  logic              rel_we;
  logic [ELEM_W-1:0] rel_q;
  logic              st_we;
  logic [CIW-1:0]    st_waddr;
  logic [STW-1:0]    st_wdata, st_q;

  logic [CIW-1:0] best;
  logic           sv1;
  logic           emit_go;

  assign emit_go   = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign vec_we    = (in_acc && room) || (state == S_PAD);
  assign vec_waddr = VAW'(ld_base + VBW'(ld_e));
  assign vec_wdata = (state == S_PAD) ? '0 : s_tdata[15:0];
  assign vec_raddr = (state == S_CHAIN_LD) ? VAW'(best_base + VBW'(k))
                                           : VAW'(dbase + VBW'(k));
  assign rel_we    = in_acc && room && (ld_e == '0);

  mds_ram #(.WIDTH(ELEM_W), .DEPTH(VD)) u_vec (
    .clk(clk), .we(vec_we), .waddr(vec_waddr), .wdata(vec_wdata),
    .raddr(vec_raddr), .rdata(vec_q)
  );

  mds_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_CANDS)) u_rel (
    .clk(clk), .we(rel_we), .waddr(ld_c[CIW-1:0]), .wdata(s_tdata[31:16]),
    .raddr(idx[CIW-1:0]), .rdata(rel_q)
  );

  mds_ram #(.WIDTH(STW), .DEPTH(MAX_CANDS)) u_state (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(idx[CIW-1:0]), .rdata(st_q)
  );

  // scan pipeline: read -> products -> score -> compare
  logic [CIW-1:0]        idx1, idx2, idx3;
  logic                  sv2, sv3, flag2, flag3, have;
  logic signed [33:0]    p1;
  logic signed [41:0]    p2;
  logic [34:0]           p3;
  logic signed [SW-1:0]  score3, top_score, sa, sb, sc_lo;

  always_comb begin
    sa    = SW'(p1);
    sb    = SW'(p2);
    sc_lo = SW'(p3);
  end

  always_ff @(posedge clk) begin
    p1    <= $signed({1'b0, lam_c}) * $signed(rel_q);
    p2    <= $signed({1'b0, inv_c}) * $signed(st_q[SIM_W-1:16]);
    p3    <= {1'b0, inv_c} * {1'b0, st_q[15:0]};
    flag2 <= st_q[SIM_W];
    idx2  <= idx1;
    score3 <= (sa <<< 14) - ((sb <<< 16) + sc_lo);
    flag3  <= flag2;
    idx3   <= idx2;
  end

  // dot-product path against the cell chain
  logic                     vdv_ld, vdv_dot, keep_d, pv, chain_en;
  logic signed [ELEM_W-1:0] feed;
  logic signed [ELEM_W-1:0] chain [MAX_DIM];
  logic signed [31:0]       prod;
  logic signed [AW-1:0]     acc, acc_sat;
  logic signed [SIM_W-1:0]  dsat;

  assign chain_en = vdv_ld | vdv_dot;
  assign feed = vdv_ld ? (keep_d ? $signed(vec_q) : '0) : chain[MAX_DIM-1];

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    if (g == 0) begin : g_head
      mds_cell u_cell (.clk(clk), .en(chain_en), .d(feed), .q(chain[g]));
    end else begin : g_body
      mds_cell u_cell (.clk(clk), .en(chain_en), .d(chain[g-1]), .q(chain[g]));
    end
  end

  always_comb begin
    if (acc > SMAX) begin
      acc_sat = SMAX;
    end else if (acc < SMIN) begin
      acc_sat = SMIN;
    end else begin
      acc_sat = acc;
    end
    dsat = acc_sat[SIM_W-1:0];
  end

  // elements past the set dimension hold no data of this set; they add nothing
  always_ff @(posedge clk) begin
    prod <= keep_d ? $signed(vec_q) * chain[MAX_DIM-1] : 32'sd0;
  end

  // state-RAM write port
  always_comb begin
    st_we    = 1'b0;
    st_waddr = idx[CIW-1:0];
    st_wdata = '0;
    priority case (1'b1)
      state == S_CLEAR: st_we = 1'b1;
      state == S_EMIT: begin
        st_we    = emit_go;
        st_waddr = best;
        st_wdata = {1'b1, {SIM_W{1'b0}}};
      end
      state == S_DOT_END: begin
        st_we    = (drain == 2'd2) && !st_q[SIM_W] && (dsat > $signed(st_q[SIM_W-1:0]));
        st_wdata = {1'b0, dsat};
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      ld_c     <= '0;
      ld_e     <= '0;
      ld_base  <= '0;
      m_tvalid <= 1'b0;
      sv1      <= 1'b0;
      sv2      <= 1'b0;
      sv3      <= 1'b0;
      vdv_ld   <= 1'b0;
      vdv_dot  <= 1'b0;
      pv       <= 1'b0;
      have     <= 1'b0;
    end else begin
      sv1     <= (state == S_SCAN);
      idx1    <= idx[CIW-1:0];
      sv2     <= sv1;
      sv3     <= sv2;
      vdv_ld  <= (state == S_CHAIN_LD);
      keep_d  <= k < set_dim;
      vdv_dot <= (state == S_DOT_RUN);
      pv      <= vdv_dot;
      if (pv) begin
        acc <= acc + AW'(prod);
      end
      if (sv3 && !flag3 && (!have || score3 > top_score)) begin
        have      <= 1'b1;
        best      <= idx3;
        top_score <= score3;
      end
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (first_elem) begin
              set_dim <= dim_use;
            end
            if (s_tlast) begin
              if (room && e_inc != dim_use) begin
                ncand <= ld_c + 1'b1;
                ld_e  <= e_inc;
                state <= S_PAD;
              end else begin
                ncand <= (room ? ld_c + 1'b1 : ld_c);
                ld_c    <= '0;
                ld_e    <= '0;
                ld_base <= '0;
                idx     <= '0;
                state   <= S_CLEAR;
              end
            end else if (room) begin
              if (e_inc == dim_use) begin
                ld_e    <= '0;
                ld_c    <= ld_c + 1'b1;
                ld_base <= ld_base + VBW'(MAX_DIM);
              end else begin
                ld_e <= e_inc;
              end
            end
          end
        end
        S_PAD: begin
          if (e_inc == set_dim) begin
            ld_c    <= '0;
            ld_e    <= '0;
            ld_base <= '0;
            idx     <= '0;
            state   <= S_CLEAR;
          end else begin
            ld_e <= e_inc;
          end
        end
        S_CLEAR: begin
          if (idx == ncand - 1'b1) begin
            npicks <= 7'(np_w);
            lam_c  <= lam_sat;
            inv_c  <= LAM_ONE - lam_sat;
            rank   <= '0;
            idx    <= '0;
            have   <= 1'b0;
            state  <= (np_w == '0) ? S_LOAD : S_SCAN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SCAN: begin
          if (idx == ncand - 1'b1) begin
            drain <= '0;
            state <= S_SCAN_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SCAN_END: begin
          drain <= drain + 1'b1;
          if (drain == 2'd2) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata   <= {RANK_W'(rank), IDX_W'(best)};
            m_tlast   <= (rank + 1'b1 == npicks);
            best_base <= VBW'(VBW'(best) * VBW'(MAX_DIM));
            rank      <= rank + 1'b1;
            k         <= '0;
            state     <= (rank + 1'b1 == npicks) ? S_LOAD : S_CHAIN_LD;
          end
        end
        S_CHAIN_LD: begin
          if (k == DW'(MAX_DIM - 1)) begin
            k     <= '0;
            idx   <= '0;
            dbase <= '0;
            acc   <= '0;
            state <= S_DOT_RUN;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DOT_RUN: begin
          if (k == DW'(MAX_DIM - 1)) begin
            drain <= '0;
            state <= S_DOT_END;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DOT_END: begin
          drain <= drain + 1'b1;
          if (drain == 2'd2) begin
            acc <= '0;
            k   <= '0;
            if (idx == ncand - 1'b1) begin
              idx   <= '0;
              have  <= 1'b0;
              state <= S_SCAN;
            end else begin
              idx   <= idx + 1'b1;
              dbase <= dbase + VBW'(MAX_DIM);
              state <= S_DOT_RUN;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire
